@@ rtl/dsph_pkg.sv @@
package dsph_pkg;

  localparam int MAX_VERTICES  = 64;
  localparam int EDGE_CAPACITY = 1024;
  localparam int WEIGHT_BITS   = 16;

  localparam int VX_W   = $clog2(MAX_VERTICES);
  localparam int CNT_W  = VX_W + 1;
  localparam int EA_W   = $clog2(EDGE_CAPACITY);
  localparam int ECNT_W = EA_W + 1;
  localparam int COST_W = 32;
  localparam int PRED_W = 7;

  localparam logic [COST_W-1:0] UNREACHED = 32'hFFFF_FFFF;
  localparam logic [COST_W-1:0] COST_CAP  = 32'hFFFF_FFFE;
  localparam logic [PRED_W-1:0] NO_PRED   = 7'h7F;

  localparam logic CFG_VERTEX_COUNT  = 1'b0;
  localparam logic CFG_TARGET_VERTEX = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE, S_LOAD, S_INIT,
    S_POP0, S_POP1, S_POP2, S_SDC,
    S_SD0, S_SD1, S_SD2, S_SD3, S_SD4,
    S_UCOST, S_UCHK,
    S_ERD, S_EGET, S_ECMP,
    S_SRCH, S_SRCH1, S_INS,
    S_SU0, S_SU1, S_SU2,
    S_PRED, S_NEXT, S_TGT, S_TGT1,
    S_EMA, S_EMB
  } dsph_state_t;

endpackage

@@ rtl/dsph_ram.sv @@
module dsph_ram #(
  parameter int DW    = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DW-1:0]            wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DW-1:0]            rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/dijkstra_shortest_path_heap_unit.sv @@
// Shortest-path engine. Edges are loaded one per transaction (start high, busy
// low); the tail pointer of each edge's source list is read from memory before
// the new edge is linked in. The transaction that carries in_last_edge starts
// a Dijkstra search from vertex 0 over a binary min-heap held in memory, one
// memory access per heap step, so the search time depends on the graph. For
// each popped vertex the heap is sifted down level by level, then its edges
// are walked (those whose destination lies outside the count are skipped);
// for each relaxing edge the heap is scanned linearly for the destination,
// which is sifted up if found, else it is appended and sifted up when it had
// no predecessor and the heap has room, and then the predecessor is written.
// Before the search a table initialisation pass runs over every vertex in
// use. One record per vertex in use then follows, each shown for a single
// cycle with out_valid; the receiver cannot stall, so take every record as it
// comes. busy stays high from the accepted last edge until the final record
// has gone, and the edge store is then empty again.
// Configuration writes are always accepted; write only while busy is low.
module dijkstra_shortest_path_heap_unit
  import dsph_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [5:0]               in_from_vertex,
  input  logic [5:0]               in_to_vertex,
  input  logic [15:0]              in_edge_cost,
  input  logic                     in_last_edge,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic                     cfg_index,
  input  logic [6:0]               cfg_data,
  output logic                     out_valid,
  output logic [5:0]               out_vertex_index,
  output logic [31:0]              out_path_cost,
  output logic signed [6:0]        out_predecessor,
  output logic                     out_target_reached,
  output logic                     out_edges_dropped,
  output logic                     out_last_record
);

  // Control state
  dsph_state_t              state_r, state_nxt;
  logic [ECNT_W-1:0]        ecnt_r, ecnt_nxt;
  logic                     ovf_r, ovf_nxt;
  logic [MAX_VERTICES-1:0]  lvalid_r, lvalid_nxt;
  logic [CNT_W-1:0]         vcnt_r;
  logic [VX_W-1:0]          tgt_r;

  // Working registers
  logic [VX_W-1:0]          fv_r, fv_nxt, tv_r, tv_nxt;
  logic [WEIGHT_BITS-1:0]   w_r, w_nxt;
  logic                     last_r, last_nxt;
  logic [CNT_W-1:0]         n_r, n_nxt, hsize_r, hsize_nxt, i_r, i_nxt, k_r, k_nxt;
  logic [CNT_W-1:0]         c_r, c_nxt;
  logic [VX_W-1:0]          p_r, p_nxt;
  logic [VX_W-1:0]          u_r, u_nxt, t_r, t_nxt, v_r, v_nxt;
  logic [VX_W-1:0]          vc_r, vc_nxt, vc2_r, vc2_nxt, vq_r, vq_nxt;
  logic [COST_W-1:0]        cu_r, cu_nxt, nd_r, nd_nxt, cv_r, cv_nxt;
  logic [COST_W-1:0]        ccost_r, ccost_nxt;
  logic [EA_W-1:0]          e_r, e_nxt, etail_r, etail_nxt, link_r, link_nxt;
  logic                     predm1_r, predm1_nxt, su_ins_r, su_ins_nxt;
  logic                     reached_r, reached_nxt;

  // Memory ports
  logic                          ed_we, lk_we, hd_we, tl_we, co_we, pr_we, hp_we;
  logic [EA_W-1:0]               ed_wa, ed_ra, lk_wa, lk_ra, lk_wd;
  logic [VX_W+WEIGHT_BITS-1:0]   ed_wd, ed_rd;
  logic [EA_W-1:0]               lk_rd;
  logic [VX_W-1:0]               hd_wa, hd_ra, tl_wa, tl_ra;
  logic [EA_W-1:0]               hd_wd, hd_rd, tl_wd, tl_rd;
  logic [VX_W-1:0]               co_wa, co_ra, pr_wa, pr_ra, hp_wa, hp_ra;
  logic [COST_W-1:0]             co_wd, co_rd;
  logic [PRED_W-1:0]             pr_wd, pr_rd;
  logic [VX_W-1:0]               hp_wd, hp_rd;

  logic [COST_W:0]               sum;
  logic [COST_W-1:0]             sat_sum;

  dsph_ram #(.DW(VX_W+WEIGHT_BITS), .DEPTH(EDGE_CAPACITY)) u_edge (
    .clk, .we(ed_we), .waddr(ed_wa), .wdata(ed_wd), .raddr(ed_ra), .rdata(ed_rd));
  dsph_ram #(.DW(EA_W), .DEPTH(EDGE_CAPACITY)) u_link (
    .clk, .we(lk_we), .waddr(lk_wa), .wdata(lk_wd), .raddr(lk_ra), .rdata(lk_rd));
  dsph_ram #(.DW(EA_W), .DEPTH(MAX_VERTICES)) u_head (
    .clk, .we(hd_we), .waddr(hd_wa), .wdata(hd_wd), .raddr(hd_ra), .rdata(hd_rd));
  dsph_ram #(.DW(EA_W), .DEPTH(MAX_VERTICES)) u_tail (
    .clk, .we(tl_we), .waddr(tl_wa), .wdata(tl_wd), .raddr(tl_ra), .rdata(tl_rd));
  dsph_ram #(.DW(COST_W), .DEPTH(MAX_VERTICES)) u_cost (
    .clk, .we(co_we), .waddr(co_wa), .wdata(co_wd), .raddr(co_ra), .rdata(co_rd));
  dsph_ram #(.DW(PRED_W), .DEPTH(MAX_VERTICES)) u_pred (
    .clk, .we(pr_we), .waddr(pr_wa), .wdata(pr_wd), .raddr(pr_ra), .rdata(pr_rd));
  dsph_ram #(.DW(VX_W), .DEPTH(MAX_VERTICES)) u_heap (
    .clk, .we(hp_we), .waddr(hp_wa), .wdata(hp_wd), .raddr(hp_ra), .rdata(hp_rd));

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  // Records come straight off the registered memory outputs
  assign out_valid          = (state_r == S_EMB);
  assign out_vertex_index   = i_r[VX_W-1:0];
  assign out_path_cost      = co_rd;
  assign out_predecessor    = pr_rd;
  assign out_target_reached = reached_r;
  assign out_edges_dropped  = ovf_r;
  assign out_last_record    = (i_r == n_r - CNT_W'(1));

  // Saturating relaxation sum
  assign sum     = {1'b0, cu_r} + (COST_W+1)'(ed_rd[WEIGHT_BITS-1:0]);
  assign sat_sum = (sum > {1'b0, COST_CAP}) ? COST_CAP : sum[COST_W-1:0];

  always_comb begin
    state_nxt = state_r;   ecnt_nxt = ecnt_r;     ovf_nxt = ovf_r;
    lvalid_nxt = lvalid_r; fv_nxt = fv_r;         tv_nxt = tv_r;
    w_nxt = w_r;           last_nxt = last_r;     n_nxt = n_r;
    hsize_nxt = hsize_r;   i_nxt = i_r;           k_nxt = k_r;
    c_nxt = c_r;           p_nxt = p_r;           u_nxt = u_r;
    t_nxt = t_r;           v_nxt = v_r;           vc_nxt = vc_r;
    vc2_nxt = vc2_r;       vq_nxt = vq_r;         cu_nxt = cu_r;
    nd_nxt = nd_r;         cv_nxt = cv_r;         ccost_nxt = ccost_r;
    e_nxt = e_r;           etail_nxt = etail_r;   link_nxt = link_r;
    predm1_nxt = predm1_r; su_ins_nxt = su_ins_r; reached_nxt = reached_r;

    ed_we = 1'b0; ed_wa = ecnt_r[EA_W-1:0]; ed_wd = {tv_r, w_r}; ed_ra = e_r;
    lk_we = 1'b0; lk_wa = tl_rd; lk_wd = ecnt_r[EA_W-1:0]; lk_ra = e_r;
    hd_we = 1'b0; hd_wa = fv_r; hd_wd = ecnt_r[EA_W-1:0]; hd_ra = u_r;
    tl_we = 1'b0; tl_wa = fv_r; tl_wd = ecnt_r[EA_W-1:0]; tl_ra = u_r;
    co_we = 1'b0; co_wa = t_r; co_wd = nd_r; co_ra = t_r;
    pr_we = 1'b0; pr_wa = t_r; pr_wd = {1'b0, u_r}; pr_ra = t_r;
    hp_we = 1'b0; hp_wa = p_r; hp_wd = t_r; hp_ra = '0;

    case (state_r)
      S_IDLE: begin
        // Read the source list tail now, link the edge next cycle
        tl_ra = in_from_vertex;
        if (start) begin
          fv_nxt = in_from_vertex;
          tv_nxt = in_to_vertex;
          w_nxt = in_edge_cost[WEIGHT_BITS-1:0];
          last_nxt = in_last_edge;
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        if (!ecnt_r[EA_W]) begin
          ed_we = 1'b1;
          if (lvalid_r[fv_r]) begin
            lk_we = 1'b1;
          end else begin
            hd_we = 1'b1;
          end
          tl_we = 1'b1;
          lvalid_nxt[fv_r] = 1'b1;
          ecnt_nxt = ecnt_r + ECNT_W'(1);
        end else begin
          ovf_nxt = 1'b1;
        end
        if (last_r) begin
          if (vcnt_r == '0) begin
            n_nxt = CNT_W'(1);
          end else if (vcnt_r > CNT_W'(MAX_VERTICES)) begin
            n_nxt = CNT_W'(MAX_VERTICES);
          end else begin
            n_nxt = vcnt_r;
          end
          i_nxt = '0;
          state_nxt = S_INIT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_INIT: begin
        co_we = 1'b1; co_wa = i_r[VX_W-1:0];
        co_wd = (i_r == '0) ? '0 : UNREACHED;
        pr_we = 1'b1; pr_wa = i_r[VX_W-1:0]; pr_wd = NO_PRED;
        if (i_r == '0) begin
          hp_we = 1'b1; hp_wa = '0; hp_wd = '0;
        end
        i_nxt = i_r + CNT_W'(1);
        if (i_r == n_r - CNT_W'(1)) begin
          hsize_nxt = CNT_W'(1);
          state_nxt = S_POP0;
        end
      end
      S_POP0: begin
        hp_ra = '0;
        state_nxt = S_POP1;
      end
      S_POP1: begin
        u_nxt = hp_rd;
        hp_ra = VX_W'(hsize_r - CNT_W'(1));
        state_nxt = S_POP2;
      end
      S_POP2: begin
        // Park the popped vertex in the freed slot, sift the last one down
        v_nxt = hp_rd;
        hp_we = 1'b1; hp_wa = VX_W'(hsize_r - CNT_W'(1)); hp_wd = u_r;
        hsize_nxt = hsize_r - CNT_W'(1);
        co_ra = hp_rd;
        p_nxt = '0;
        state_nxt = S_SDC;
      end
      S_SDC: begin
        cv_nxt = co_rd;
        state_nxt = S_SD0;
      end
      S_SD0: begin
        c_nxt = {p_r, 1'b1};
        if ({p_r, 1'b1} < hsize_r) begin
          hp_ra = VX_W'({p_r, 1'b1});
          state_nxt = S_SD1;
        end else begin
          hp_we = 1'b1; hp_wa = p_r; hp_wd = v_r;
          state_nxt = S_UCOST;
        end
      end
      S_SD1: begin
        vc_nxt = hp_rd;
        co_ra = hp_rd;
        hp_ra = VX_W'(c_r + CNT_W'(1));
        state_nxt = S_SD2;
      end
      S_SD2: begin
        ccost_nxt = co_rd;
        if (c_r + CNT_W'(1) < hsize_r) begin
          vc2_nxt = hp_rd;
          co_ra = hp_rd;
          state_nxt = S_SD3;
        end else begin
          state_nxt = S_SD4;
        end
      end
      S_SD3: begin
        if (ccost_r > co_rd) begin
          c_nxt = c_r + CNT_W'(1);
          vc_nxt = vc2_r;
          ccost_nxt = co_rd;
        end
        state_nxt = S_SD4;
      end
      S_SD4: begin
        hp_we = 1'b1; hp_wa = p_r;
        if (cv_r > ccost_r) begin
          hp_wd = vc_r;
          p_nxt = c_r[VX_W-1:0];
          state_nxt = S_SD0;
        end else begin
          hp_wd = v_r;
          state_nxt = S_UCOST;
        end
      end
      S_UCOST: begin
        co_ra = u_r;
        state_nxt = S_UCHK;
      end
      S_UCHK: begin
        cu_nxt = co_rd;
        e_nxt = hd_rd;
        etail_nxt = tl_rd;
        if (co_rd == UNREACHED) begin
          // Skip the target check as well
          state_nxt = (hsize_r == '0) ? S_EMA : S_POP0;
          reached_nxt = 1'b0;
          i_nxt = '0;
        end else if (!lvalid_r[u_r]) begin
          state_nxt = S_TGT;
        end else begin
          state_nxt = S_ERD;
        end
      end
      S_ERD: begin
        state_nxt = S_EGET;
      end
      S_EGET: begin
        t_nxt = ed_rd[VX_W+WEIGHT_BITS-1:WEIGHT_BITS];
        link_nxt = lk_rd;
        nd_nxt = sat_sum;
        co_ra = ed_rd[VX_W+WEIGHT_BITS-1:WEIGHT_BITS];
        pr_ra = ed_rd[VX_W+WEIGHT_BITS-1:WEIGHT_BITS];
        if (CNT_W'(ed_rd[VX_W+WEIGHT_BITS-1:WEIGHT_BITS]) >= n_r) begin
          state_nxt = S_NEXT;
        end else begin
          state_nxt = S_ECMP;
        end
      end
      S_ECMP: begin
        if (co_rd > nd_r) begin
          co_we = 1'b1;
          predm1_nxt = (pr_rd == NO_PRED);
          su_ins_nxt = 1'b0;
          k_nxt = '0;
          state_nxt = S_SRCH;
        end else begin
          state_nxt = S_NEXT;
        end
      end
      S_SRCH: begin
        hp_ra = k_r[VX_W-1:0];
        state_nxt = (k_r == hsize_r) ? S_INS : S_SRCH1;
      end
      S_SRCH1: begin
        if (hp_rd == t_r) begin
          p_nxt = k_r[VX_W-1:0];
          state_nxt = S_SU0;
        end else begin
          k_nxt = k_r + CNT_W'(1);
          state_nxt = S_SRCH;
        end
      end
      S_INS: begin
        if (predm1_r && (hsize_r < n_r)) begin
          p_nxt = hsize_r[VX_W-1:0];
          hsize_nxt = hsize_r + CNT_W'(1);
          su_ins_nxt = 1'b1;
          state_nxt = S_SU0;
        end else begin
          state_nxt = S_PRED;
        end
      end
      S_SU0: begin
        hp_ra = (p_r - VX_W'(1)) >> 1;
        if (p_r == '0) begin
          hp_we = 1'b1;
          state_nxt = su_ins_r ? S_PRED : S_INS;
        end else begin
          state_nxt = S_SU1;
        end
      end
      S_SU1: begin
        vq_nxt = hp_rd;
        co_ra = hp_rd;
        state_nxt = S_SU2;
      end
      S_SU2: begin
        hp_we = 1'b1;
        if (co_rd > nd_r) begin
          hp_wd = vq_r;
          p_nxt = (p_r - VX_W'(1)) >> 1;
          state_nxt = S_SU0;
        end else begin
          state_nxt = su_ins_r ? S_PRED : S_INS;
        end
      end
      S_PRED: begin
        pr_we = 1'b1;
        state_nxt = S_NEXT;
      end
      S_NEXT: begin
        if (e_r == etail_r) begin
          state_nxt = S_TGT;
        end else begin
          e_nxt = link_r;
          state_nxt = S_ERD;
        end
      end
      S_TGT: begin
        hp_ra = '0;
        state_nxt = S_TGT1;
      end
      S_TGT1: begin
        i_nxt = '0;
        if (hp_rd == tgt_r) begin
          reached_nxt = 1'b1;
          state_nxt = S_EMA;
        end else if (hsize_r == '0) begin
          reached_nxt = 1'b0;
          state_nxt = S_EMA;
        end else begin
          state_nxt = S_POP0;
        end
      end
      S_EMA: begin
        co_ra = i_r[VX_W-1:0];
        pr_ra = i_r[VX_W-1:0];
        state_nxt = S_EMB;
      end
      S_EMB: begin
        if (i_r == n_r - CNT_W'(1)) begin
          // Drop the loaded graph
          lvalid_nxt = '0;
          ecnt_nxt = '0;
          ovf_nxt = 1'b0;
          state_nxt = S_IDLE;
        end else begin
          i_nxt = i_r + CNT_W'(1);
          state_nxt = S_EMA;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ecnt_r   <= '0;
      ovf_r    <= 1'b0;
      lvalid_r <= '0;
      vcnt_r   <= CNT_W'(MAX_VERTICES);
      tgt_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      ecnt_r   <= ecnt_nxt;
      ovf_r    <= ovf_nxt;
      lvalid_r <= lvalid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_VERTEX_COUNT:  vcnt_r <= cfg_data;
          CFG_TARGET_VERTEX: tgt_r  <= cfg_data[VX_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    fv_r <= fv_nxt;         tv_r <= tv_nxt;         w_r <= w_nxt;
    last_r <= last_nxt;     n_r <= n_nxt;           hsize_r <= hsize_nxt;
    i_r <= i_nxt;           k_r <= k_nxt;           c_r <= c_nxt;
    p_r <= p_nxt;           u_r <= u_nxt;           t_r <= t_nxt;
    v_r <= v_nxt;           vc_r <= vc_nxt;         vc2_r <= vc2_nxt;
    vq_r <= vq_nxt;         cu_r <= cu_nxt;         nd_r <= nd_nxt;
    cv_r <= cv_nxt;         ccost_r <= ccost_nxt;   e_r <= e_nxt;
    etail_r <= etail_nxt;   link_r <= link_nxt;     predm1_r <= predm1_nxt;
    su_ins_r <= su_ins_nxt; reached_r <= reached_nxt;
  end

endmodule
